// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ipipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipipc_pkg
// Constants, register map and saturation helpers of the PI position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipipc_pkg;

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_SPEED_LIMIT    = 2'd0;
    localparam logic [1:0] REG_COEF_NOW       = 2'd1;
    localparam logic [1:0] REG_COEF_PREV      = 2'd2;
    localparam logic [1:0] REG_POSITION_SCALE = 2'd3;

    // Reset values.
    localparam logic [7:0]  SPEED_LIMIT_RST    = 8'd150;
    localparam logic [15:0] COEF_NOW_RST       = 16'd6341;
    localparam logic [15:0] COEF_PREV_RST      = 16'd6144;
    localparam logic [15:0] POSITION_SCALE_RST = 16'd1769;

    // Datapath widths.
    localparam int OPW  = 17;        // multiplier operand width
    localparam int PRW  = 2 * OPW;   // product and accumulator width
    localparam int DRVW = 9;         // drive width

    typedef logic signed [OPW-1:0]  op_t;
    typedef logic signed [PRW-1:0]  prod_t;
    typedef logic signed [DRVW-1:0] drive_t;

    // Negation of a 16-bit count, saturating the most negative value.
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000) begin
            r = 16'sh7fff;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // Saturate an 18-bit signed value to the 16-bit signed range.
    function automatic logic signed [15:0] sat18to16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/incremental_pi_position_controller_core.sv =====
// An input transfer steps the sequencer through POS_MUL, ERR, NOW_MUL, PREV_MUL,
// DIFF and DONE before the result becomes valid; a new item is taken only in
// IDLE, once the last one is through. The shared 17x17 multiplier runs three
// products per item under a seven-state sequencer.
// A result waiting in the output register keeps the sequencer in DONE and s_ready low.
// Reset (aresetn low at a clock edge) restores the register defaults, clears
// the stored error and drive, and empties the output register.
// ----------------------------------------------------------------------------
// incremental_pi_position_controller_core
// Velocity-form PI position controller with one shared multiplier and an
// APB-style configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module incremental_pi_position_controller_core
    import ipipc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // Input channel: one transfer per control tick.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_encoder_count,
    input  logic        [7:0]  s_reference,

    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_direction,
    output logic        [7:0]  m_speed,

    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    // Sequencer states. The item walks through these once; the multiplier is
    // used in POS_MUL, NOW_MUL and PREV_MUL, each product landing in prod_reg.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_POS_MUL  = 3'd1;
    localparam logic [2:0] ST_ERR      = 3'd2;
    localparam logic [2:0] ST_NOW_MUL  = 3'd3;
    localparam logic [2:0] ST_PREV_MUL = 3'd4;
    localparam logic [2:0] ST_DIFF     = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [7:0]  speed_limit_reg;
    logic [15:0] coef_now_reg;
    logic [15:0] coef_prev_reg;
    logic [15:0] position_scale_reg;

    // Per-item working registers.
    logic signed [15:0] neg_reg;     // negated, saturated encoder count
    logic        [7:0]  ref_reg;
    logic signed [15:0] err_reg;
    prod_t              prod_reg;
    prod_t              acc_reg;

    // Controller state carried from one tick to the next.
    logic signed [15:0] last_err_reg;
    drive_t             last_drive_reg;

    // Output register.
    logic        m_valid_reg;
    logic        m_direction_reg;
    logic [7:0]  m_speed_reg;

    logic        cfg_wr;
    logic        out_free;

    // Shared multiplier.
    op_t   mul_a;
    op_t   mul_b;
    prod_t mul_p;

    // Datapath between multiplications.
    prod_t              pos_round;
    prod_t              pos_shift;
    logic signed [17:0] err_wide;
    logic signed [15:0] err_sat;
    prod_t              acc_round;
    prod_t              acc_shift;
    logic signed [22:0] drive_sum;
    logic signed [22:0] lim_pos;
    logic signed [22:0] lim_neg;
    logic signed [22:0] drive_clamped;
    drive_t             drive;
    drive_t             drive_mag;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // served combinationally from the register selected by paddr.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_limit_reg    <= SPEED_LIMIT_RST;
            coef_now_reg       <= COEF_NOW_RST;
            coef_prev_reg      <= COEF_PREV_RST;
            position_scale_reg <= POSITION_SCALE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SPEED_LIMIT:    speed_limit_reg    <= pwdata[7:0];
                REG_COEF_NOW:       coef_now_reg       <= pwdata[15:0];
                REG_COEF_PREV:      coef_prev_reg      <= pwdata[15:0];
                REG_POSITION_SCALE: position_scale_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED_LIMIT:    prdata = {24'd0, speed_limit_reg};
            REG_COEF_NOW:       prdata = {16'd0, coef_now_reg};
            REG_COEF_PREV:      prdata = {16'd0, coef_prev_reg};
            REG_POSITION_SCALE: prdata = {16'd0, position_scale_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand selection. Coefficients are unsigned and
    // enter as non-negative 17-bit values.
    // ------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            ST_POS_MUL: begin
                mul_a = op_t'(neg_reg);
                mul_b = op_t'({1'b0, position_scale_reg});
            end
            ST_NOW_MUL: begin
                mul_a = op_t'(err_reg);
                mul_b = op_t'({1'b0, coef_now_reg});
            end
            default: begin
                mul_a = op_t'(last_err_reg);
                mul_b = op_t'({1'b0, coef_prev_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Position and error. The product, with 16 fractional bits from the Q0.16
    // scale, is divided by 2^16 with truncation toward zero: a negative product
    // is biased before the arithmetic shift. The error is saturated to 16 bits.
    // ------------------------------------------------------------------
    assign pos_round = prod_reg[PRW-1] ? prod_reg + prod_t'(65535) : prod_reg;
    assign pos_shift = pos_round >>> 16;
    assign err_wide  = $signed({10'd0, ref_reg}) - pos_shift[17:0];
    assign err_sat   = sat18to16(err_wide);

    // ------------------------------------------------------------------
    // Drive update. The difference of the products, with 12 fractional bits from
    // the Q4.12 gains, is divided by 2^12 toward zero, added to the previous drive
    // and clamped to the speed limit. A zero limit forces the drive to zero.
    // ------------------------------------------------------------------
    assign acc_round = acc_reg[PRW-1] ? acc_reg + prod_t'(4095) : acc_reg;
    assign acc_shift = acc_round >>> 12;
    assign drive_sum = acc_shift[22:0] + 23'(last_drive_reg);
    assign lim_pos   = $signed({15'd0, speed_limit_reg});
    assign lim_neg   = -lim_pos;

    always_comb begin
        if (drive_sum > lim_pos) begin
            drive_clamped = lim_pos;
        end else if (drive_sum < lim_neg) begin
            drive_clamped = lim_neg;
        end else begin
            drive_clamped = drive_sum;
        end
    end

    assign drive     = drive_clamped[DRVW-1:0];
    assign drive_mag = drive[DRVW-1] ? -drive : drive;

    // ------------------------------------------------------------------
    // Sequencer. A new item is taken only in IDLE; the last step waits
    // until the output register is free, so a result that is still
    // waiting keeps the sequencer in DONE and the next item out.
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_POS_MUL;
            ST_POS_MUL:  state_next = ST_ERR;
            ST_ERR:      state_next = ST_NOW_MUL;
            ST_NOW_MUL:  state_next = ST_PREV_MUL;
            ST_PREV_MUL: state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_err_reg   <= 16'sd0;
            last_drive_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                last_err_reg   <= err_reg;
                last_drive_reg <= drive;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_reg <= neg_sat16(s_encoder_count);
                    ref_reg <= s_reference;
                end
            end
            ST_POS_MUL: prod_reg <= mul_p;
            ST_ERR:     err_reg  <= err_sat;
            ST_NOW_MUL: prod_reg <= mul_p;
            ST_PREV_MUL: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_DIFF:    acc_reg <= acc_reg - prod_reg;
            ST_DONE: begin
                if (out_free) begin
                    m_direction_reg <= drive[DRVW-1];
                    m_speed_reg     <= drive_mag[7:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_direction = m_direction_reg;
    assign m_speed     = m_speed_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_POS_MUL, "accepted item did not start the sequence")
    `ASSERT_NEXT(a_done_delivers, aclk, aresetn, state_reg == ST_DONE && out_free, m_valid_reg && state_reg == ST_IDLE, "finished item not placed in output register")
    `ASSERT_IMPL(a_speed_limited, aclk, aresetn, m_valid_reg, m_speed_reg <= speed_limit_reg, "result speed exceeds speed limit")
    `ASSERT_IMPL(a_left_nonzero, aclk, aresetn, m_valid_reg && m_direction_reg, m_speed_reg != 8'd0, "negative drive reported with zero speed")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the incremental PI position controller. A directed
// set of control ticks covers the count and reference extremes, the count that
// cannot be negated, error saturation and a zero speed limit. Random ticks then
// run under several register settings while both channels idle at random.
// A tracker class predicts every drive command and checks each result transfer.
// ----------------------------------------------------------------------------

module testbench
    import ipipc_pkg::*;
();

    // The bench gives up after this many cycles in which nothing transfers.
    localparam int IDLE_LIMIT    = 5000;
    // The core returns a result once its sequencer has stepped from POS_MUL
    // through DONE, so this covers its latency with margin.
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_TICKS   = 100;
    localparam int RANDOM_PHASES = 6;

    // One drive command as it leaves the result channel.
    typedef struct packed {
        logic       direction;
        logic [7:0] speed;
    } motor_cmd_t;

    // Tracks the controller state and the commands still owed by the core.
    class drive_tracker;
        logic [7:0]         speed_limit;
        logic [15:0]        coef_now;
        logic [15:0]        coef_prev;
        logic [15:0]        position_scale;
        logic signed [15:0] last_error;
        logic signed [8:0]  last_drive;
        motor_cmd_t         pending_cmds[$];
        int                 mismatches;
        int                 ticks_seen;
        int                 cmds_seen;

        function new();
            speed_limit    = SPEED_LIMIT_RST;
            coef_now       = COEF_NOW_RST;
            coef_prev      = COEF_PREV_RST;
            position_scale = POSITION_SCALE_RST;
            last_error     = '0;
            last_drive     = '0;
            mismatches     = 0;
            ticks_seen     = 0;
            cmds_seen      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SPEED_LIMIT:    speed_limit    = value[7:0];
                REG_COEF_NOW:       coef_now       = value[15:0];
                REG_COEF_PREV:      coef_prev      = value[15:0];
                REG_POSITION_SCALE: position_scale = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [1:0] idx);
            logic [31:0] value;
            case (idx)
                REG_SPEED_LIMIT:    value = {24'd0, speed_limit};
                REG_COEF_NOW:       value = {16'd0, coef_now};
                REG_COEF_PREV:      value = {16'd0, coef_prev};
                REG_POSITION_SCALE: value = {16'd0, position_scale};
                default:            value = '0;
            endcase
            return value;
        endfunction

        // Runs one control tick and queues the command that it must produce.
        function void note_tick(logic signed [15:0] count, logic [7:0] refpos);
            longint     neg_count;
            longint     position;
            longint     err;
            longint     delta;
            longint     limit;
            longint     drive;
            motor_cmd_t cmd;
            // Negating the most negative count saturates.
            if (count == -16'sd32768) begin
                neg_count = 32767;
            end else begin
                neg_count = -longint'(count);
            end
            // Signed division truncates toward zero, as the datapath does.
            position = (neg_count * longint'(position_scale)) / 65536;
            err = longint'(refpos) - position;
            if (err > 32767) begin
                err = 32767;
            end else if (err < -32768) begin
                err = -32768;
            end
            delta = (longint'(coef_now) * err - longint'(coef_prev) * longint'(last_error))
                    / 4096;
            limit = longint'(speed_limit);
            drive = longint'(last_drive) + delta;
            if (drive > limit) begin
                drive = limit;
            end else if (drive < -limit) begin
                drive = -limit;
            end
            last_error    = err[15:0];
            last_drive    = drive[8:0];
            cmd.direction = (drive < 0);
            cmd.speed     = (drive < 0) ? 8'(-drive) : 8'(drive);
            pending_cmds.push_back(cmd);
            ticks_seen++;
        endfunction

        function void check_cmd(logic direction, logic [7:0] speed);
            motor_cmd_t want;
            cmds_seen++;
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result, direction %0d speed %0d",
                         $time, direction, speed);
                mismatches++;
            end else begin
                want = pending_cmds.pop_front();
                if (direction !== want.direction) begin
                    $display("%0t: direction mismatch, expected %0d, actual %0d",
                             $time, want.direction, direction);
                    mismatches++;
                end
                if (speed !== want.speed) begin
                    $display("%0t: speed mismatch, expected %0d, actual %0d",
                             $time, want.speed, speed);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_encoder_count = '0;
    logic        [7:0]  s_reference = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_direction;
    logic        [7:0]  m_speed;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic        [3:0]  paddr = '0;
    logic        [31:0] pwdata = '0;
    logic        [31:0] prdata;
    logic               pready;

    drive_tracker tracker = new();
    int           readback_errors = 0;
    int           settings_used = 0;
    int           idle_cycles = 0;
    int           rx_mode = 0;
    int           rx_count = 0;

    incremental_pi_position_controller_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_encoder_count (s_encoder_count),
        .s_reference     (s_reference),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_direction     (m_direction),
        .m_speed         (m_speed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: every accepted transfer is checked against the oldest
    // command still owed by the core.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_cmd(m_direction, m_speed);
        end
    end

    // The receiver picks a stall mode for a random stretch of cycles: always
    // ready, mostly ready, mostly stalled, or a regular on/off pattern. The
    // always-ready stretches take each result in the cycle it appears.
    always @(negedge aclk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 3);
            rx_count <= $urandom_range(20, 120);
        end else begin
            rx_count <= rx_count - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= rx_count[2];
        endcase
    end

    // Watchdog: a hung handshake on any port ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Presents one control tick and holds it until the core takes it. The
    // valid line is left high so that the next tick can follow directly.
    task automatic send_tick(input logic signed [15:0] count, input logic [7:0] refpos);
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_encoder_count <= count;
        s_reference     <= refpos;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        tracker.note_tick(count, refpos);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Holds off the sender until every owed command has been delivered.
    task automatic drain_results();
        pause_sender(1);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // A register write followed by a read of the same register.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        tracker.set_register(idx, value);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        mask = (idx == REG_SPEED_LIMIT) ? 32'h0000_00FF : 32'h0000_FFFF;
        if ((prdata & mask) !== tracker.register_value(idx)) begin
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, tracker.register_value(idx), prdata & mask);
            readback_errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // New settings go in only once the core has gone quiet.
    task automatic apply_settings(input logic [7:0] limit, input logic [15:0] gain_now,
                                  input logic [15:0] gain_prev, input logic [15:0] scale);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(REG_SPEED_LIMIT, {24'd0, limit});
        write_register(REG_COEF_NOW, {16'd0, gain_now});
        write_register(REG_COEF_PREV, {16'd0, gain_prev});
        write_register(REG_POSITION_SCALE, {16'd0, scale});
        settings_used++;
    endtask

    // Most random ticks follow a reference closely, the way a closed loop
    // would, so that the drive is not always pinned at the limit. The rest
    // are raw values over the full field ranges.
    task automatic random_tick();
        logic [7:0]         refpos;
        logic signed [15:0] count;
        int                 target;
        int                 scale;
        refpos = 8'($urandom_range(0, 255));
        scale  = (tracker.position_scale == 0) ? 1 : int'(tracker.position_scale);
        if ($urandom_range(0, 3) == 0) begin
            count = 16'($urandom);
        end else begin
            target = -((int'(refpos) * 65536) / scale) + $urandom_range(0, 400) - 200;
            if (target > 32767) begin
                target = 32767;
            end else if (target < -32768) begin
                target = -32768;
            end
            count = target[15:0];
        end
        send_tick(count, refpos);
    endtask

    initial begin
        int burst_left;
        int gap;

        // Synchronous reset, held low before the first tick.
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: count and reference extremes, including the count
        // whose negation has to saturate.
        send_tick(16'sd0, 8'd0);
        send_tick(16'sd32767, 8'd255);
        send_tick(-16'sd32768, 8'd0);
        send_tick(-16'sd32768, 8'd255);
        send_tick(-16'sd1, 8'd128);
        send_tick(16'sd1, 8'd1);
        send_tick(16'sh5555, 8'h55);
        send_tick(-16'sh5556, 8'hAA);

        // Zero speed limit forces the drive to zero whatever the error.
        apply_settings(8'd0, COEF_NOW_RST, COEF_PREV_RST, POSITION_SCALE_RST);
        send_tick(16'sd32767, 8'd255);
        send_tick(-16'sd32768, 8'd0);
        send_tick(-16'sd9000, 8'd200);

        // Full-scale gains and scaling: the error saturates in the positive
        // direction and the drive hits both ends of the widest clamp.
        apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16'sd32767, 8'd255);
        send_tick(16'sd32767, 8'd0);
        send_tick(-16'sd32768, 8'd255);
        send_tick(-16'sd32768, 8'd0);
        send_tick(16'sd0, 8'd255);

        // Zero gains hold the drive where it was; zero scaling ignores the count.
        apply_settings(8'd200, 16'd0, 16'd0, 16'd0);
        send_tick(16'sd32767, 8'd255);
        send_tick(-16'sd32768, 8'd0);
        apply_settings(8'd150, 16'd0, 16'hFFFF, 16'd1);
        send_tick(16'sd1234, 8'd17);
        send_tick(-16'sd4321, 8'd240);

        // Random part: one register setting per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(SPEED_LIMIT_RST, COEF_NOW_RST, COEF_PREV_RST,
                                  POSITION_SCALE_RST);
                1: apply_settings(8'd200, 16'($urandom_range(4096, 12000)),
                                  16'($urandom_range(2048, 8192)),
                                  16'($urandom_range(500, 4000)));
                2: apply_settings(8'd255, 16'hFFFF, 16'd0, 16'hFFFF);
                3: apply_settings(8'($urandom_range(1, 255)), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                4: apply_settings(8'd255, 16'($urandom_range(0, 8192)),
                                  16'($urandom_range(0, 8192)),
                                  16'($urandom_range(1, 65535)));
                default: apply_settings(8'd150, 16'd6341, 16'd6144, 16'd1769);
            endcase
            burst_left = 0;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // Once, midway through a phase, let the core run completely
                // dry before the next tick goes in.
                if (phase == 1 && n == PHASE_TICKS / 2) begin
                    drain_results();
                end
                // Phase 2 streams without gaps; the others come in bursts.
                if (burst_left == 0) begin
                    gap = (phase == 2) ? 0 : $urandom_range(1, 8);
                    pause_sender(gap);
                    burst_left = $urandom_range(1, 16);
                end
                random_tick();
                burst_left--;
            end
        end

        // Wait for the last commands, then give the core time to show any
        // stray result before the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d control ticks and %0d drive results under %0d register settings.",
                 tracker.ticks_seen, tracker.cmds_seen, settings_used);
        $display("Mismatches: %0d on results, %0d on register readback.",
                 tracker.mismatches, readback_errors);
        if (tracker.mismatches == 0 && readback_errors == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ipipc_pkg.sv
sv/incremental_pi_position_controller_core.sv
verif/testbench.sv
